[hw/rtl/rdc_pkg.sv]
// Shared constants, register map and lane status type of the reflectance discharge classifier.
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int unsigned CHANNELS_DEFAULT = 5;

  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned MARGIN_W = 12;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [COUNT_W-1:0]  THRESHOLD_RESET = 16'h02C0;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET    = 12'h070;
  localparam logic [COUNT_W-1:0]  TIMEOUT_RESET   = 16'h1000;
  localparam logic [COUNT_W-1:0]  COUNT_MAX       = 16'hFFFF;

  // Register indexes (byte address / 4)
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_MARGIN     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_COUNT   = 2'd2;

  // Request commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Next-cycle status of one channel lane
  typedef struct packed {
    logic done;
    logic light;
  } lane_st_t;

endpackage

[hw/rtl/rdc_lane.sv]
// One channel lane: edge detect on the pin and light/done bookkeeping.
`timescale 1ns / 1ps

module rdc_lane #(
  parameter bit IS_OUTER = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              tick_i,
  input  logic              pin_i,
  input  logic              inner_below_i,
  input  logic              outer_below_i,
  output rdc_pkg::lane_st_t st_o
);
  import rdc_pkg::*;

  logic prev_q, prev_d;
  logic done_q, done_d;
  logic light_q, light_d;
  logic changed;
  logic below;

  assign changed = pin_i ^ prev_q;
  assign below   = IS_OUTER ? outer_below_i : inner_below_i;

  always_comb begin
    prev_d  = prev_q;
    done_d  = done_q;
    light_d = light_q;
    if (start_i) begin
      prev_d  = 1'b1;
      done_d  = 1'b0;
      light_d = 1'b0;
    end else if (tick_i) begin
      prev_d  = pin_i;
      done_d  = done_q | changed;
      light_d = light_q | (changed & below);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      done_q  <= 1'b0;
      light_q <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      done_q  <= done_d;
      light_q <= light_d;
    end
  end

  assign st_o.done  = done_d;
  assign st_o.light = light_d;

endmodule

[hw/rtl/rdc_merge.sv]
// Merge stage: combine lane status, decide the end of a measurement, hold the result.
`timescale 1ns / 1ps

module rdc_merge #(
  parameter int unsigned CHANNELS = rdc_pkg::CHANNELS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              tick_i,
  input  rdc_pkg::lane_st_t [CHANNELS-1:0]  lanes_i,
  input  logic                              timeout_i,
  input  logic                              out_ready_i,
  output logic                              finish_o,
  output logic                              out_valid_o,
  output logic [CHANNELS-1:0]               light_mask_o,
  output logic                              timed_out_o
);
  import rdc_pkg::*;

  logic [CHANNELS-1:0] done_vec;
  logic [CHANNELS-1:0] light_vec;
  logic                all_done;
  logic                valid_q, valid_d;
  logic [CHANNELS-1:0] mask_q;
  logic                to_q;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      done_vec[i]  = lanes_i[i].done;
      light_vec[i] = lanes_i[i].light;
    end
  end

  assign all_done = &done_vec;
  assign finish_o = tick_i & (all_done | timeout_i);

  always_comb begin
    valid_d = valid_q;
    if (finish_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (finish_o) begin
      mask_q <= light_vec;
      to_q   <= ~all_done;
    end
  end

  assign out_valid_o  = valid_q;
  assign light_mask_o = mask_q;
  assign timed_out_o  = to_q;

endmodule

[hw/rtl/reflectance_discharge_classifier_core.sv]
// Top level of the reflectance discharge classifier: request handshake, timer, lanes, APB registers.
`timescale 1ns / 1ps

// Times the discharge of CHANNELS charged reflectance sensors and classifies each as light or
// dark. Send a start request (command 0) to open a measurement, then one tick request
// (command 1) per timer count carrying the sampled pins. A channel is done at its first pin
// change and reads light if the elapsed count was below light_threshold then (the two outer
// channels allow light_threshold + edge_margin, formed at 17 bits). When every channel is done,
// or the count reaches timeout_count, one result gives light_mask and timed_out (0 when all
// channels finished, also when both happen on the same tick). Ticks while idle are dropped;
// a start while busy abandons the running measurement without a result. Throughput is one
// request per clock: each lane and the shared count comparators settle a tick combinationally,
// and the result appears from the output register on the cycle after the finishing tick.
// The input stalls only while a result sits in that register and out_ready_i is low.
// Configuration is by APB at byte addresses 0, 4 and 8; write only while idle.

module reflectance_discharge_classifier_core #(
  parameter int unsigned CHANNELS = rdc_pkg::CHANNELS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [CHANNELS-1:0]            pins_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [CHANNELS-1:0]            light_mask_o,
  output logic                           timed_out_o,
  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rdc_pkg::APB_AW-1:0]     paddr,
  input  logic [rdc_pkg::APB_DW-1:0]     pwdata,
  output logic [rdc_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import rdc_pkg::*;

  // Configuration registers
  logic [COUNT_W-1:0]   thr_q;
  logic [MARGIN_W-1:0]  margin_q;
  logic [COUNT_W-1:0]   timeout_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  // Measurement control
  logic                 busy_q, busy_d;
  logic [COUNT_W-1:0]   elapsed_q, elapsed_d;
  logic                 in_fire;
  logic                 start_fire;
  logic                 tick_fire;
  logic                 inner_below;
  logic                 outer_below;
  logic [COUNT_W:0]     outer_thr;
  logic                 timeout;
  logic                 finish;

  lane_st_t [CHANNELS-1:0] lane_st;

  // ---------------------------------------------------------------------------
  // APB register file: pready is tied high, write on the access phase
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THRESHOLD_RESET;
      margin_q  <= MARGIN_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LIGHT_THRESHOLD: thr_q     <= pwdata[COUNT_W-1:0];
        REG_EDGE_MARGIN:     margin_q  <= pwdata[MARGIN_W-1:0];
        REG_TIMEOUT_COUNT:   timeout_q <= pwdata[COUNT_W-1:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LIGHT_THRESHOLD: prdata = {{(APB_DW-COUNT_W){1'b0}}, thr_q};
      REG_EDGE_MARGIN:     prdata = {{(APB_DW-MARGIN_W){1'b0}}, margin_q};
      REG_TIMEOUT_COUNT:   prdata = {{(APB_DW-COUNT_W){1'b0}}, timeout_q};
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request handshake: hold off only when a result would have nowhere to go
  // ---------------------------------------------------------------------------
  assign in_ready_o = ~out_valid_o | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;
  assign start_fire = in_fire & (command_i == CMD_START);
  // Ticks while idle are accepted and dropped
  assign tick_fire  = in_fire & (command_i == CMD_TICK) & busy_q;

  // ---------------------------------------------------------------------------
  // Shared threshold compares, broadcast to every lane
  // ---------------------------------------------------------------------------
  assign outer_thr   = {1'b0, thr_q} + {{(COUNT_W+1-MARGIN_W){1'b0}}, margin_q};
  assign inner_below = elapsed_q < thr_q;
  assign outer_below = {1'b0, elapsed_q} < outer_thr;

  // Elapsed count: advance on each live tick, saturate at full scale
  always_comb begin
    elapsed_d = elapsed_q;
    if (start_fire) begin
      elapsed_d = '0;
    end else if (tick_fire && (elapsed_q != COUNT_MAX)) begin
      elapsed_d = elapsed_q + 1'b1;
    end
  end

  assign timeout = elapsed_d >= timeout_q;

  always_comb begin
    busy_d = busy_q;
    if (start_fire) begin
      busy_d = 1'b1;
    end else if (finish) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      elapsed_q <= '0;
    end else begin
      busy_q    <= busy_d;
      elapsed_q <= elapsed_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel lanes: outer lanes are the first and the last
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    rdc_lane #(
      .IS_OUTER ((g == 0) || (g == CHANNELS - 1))
    ) u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .start_i       (start_fire),
      .tick_i        (tick_fire),
      .pin_i         (pins_i[g]),
      .inner_below_i (inner_below),
      .outer_below_i (outer_below),
      .st_o          (lane_st[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge lanes into the result and hold it until taken
  // ---------------------------------------------------------------------------
  rdc_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_fire),
    .lanes_i      (lane_st),
    .timeout_i    (timeout),
    .out_ready_i  (out_ready_i),
    .finish_o     (finish),
    .out_valid_o  (out_valid_o),
    .light_mask_o (light_mask_o),
    .timed_out_o  (timed_out_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A result is only produced when the output register is free or being emptied
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> (!out_valid_o || out_ready_i))
    else $error("result pushed over an undelivered result");

  // A finishing tick leaves the block idle
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> !busy_q)
    else $error("block still busy after a result");

  // A new result only ever follows a live tick
  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(tick_fire))
    else $error("result appeared without a tick");

  // A start request opens a measurement at count zero
  a_start_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_fire |=> (busy_q && (elapsed_q == '0)))
    else $error("start did not open a measurement");

endmodule

[tb/reflectance_discharge_classifier_core_test.sv]
// Self-checking testbench for the reflectance discharge classifier core.
`timescale 1ns / 1ps

// Requests are driven at the falling clock edge and all handshakes are sampled at the rising
// edge. A monitor feeds every accepted request into a discharge predictor, which queues the
// expected reading. The same monitor compares each accepted result with the oldest queued
// reading. Stimulus runs in named tests: register reset values, directed corner cases, one
// long measurement, then random well-formed measurements with noise under four
// idling phases.

module reflectance_discharge_classifier_core_test;

  import rdc_pkg::*;

  localparam int NCH = CHANNELS_DEFAULT;
  localparam logic [NCH-1:0] OUTER_LANES = NCH'(1) | (NCH'(1) << (NCH - 1));
  // Quiet cycles tolerated before the run is declared hung; the longest legitimate quiet
  // stretch is a register update plus the hold-off, well under this.
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic [NCH-1:0] light_mask;
    logic           timed_out;
  } reading_t;

  logic clk;
  logic rst_n;

  // Drive every input to a known value from time zero.
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                command  = CMD_START;
  logic [NCH-1:0]      pins     = '1;
  logic                out_valid;
  logic                out_ready = 1'b1;
  logic [NCH-1:0]      light_mask;
  logic                timed_out;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [APB_AW-1:0]   paddr    = '0;
  logic [APB_DW-1:0]   pwdata   = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Predictor copy of the registers and the measurement state.
  logic [COUNT_W-1:0]  cfg_threshold = THRESHOLD_RESET;
  logic [MARGIN_W-1:0] cfg_margin    = MARGIN_RESET;
  logic [COUNT_W-1:0]  cfg_timeout   = TIMEOUT_RESET;
  logic [COUNT_W-1:0]  elapsed_count = '0;
  logic [NCH-1:0]      last_pins     = '1;
  logic [NCH-1:0]      light_seen    = '0;
  logic [NCH-1:0]      done_seen     = '0;
  logic                measuring     = 1'b0;

  reading_t expected_readings[$];

  int error_count        = 0;
  int quiet_cycles       = 0;
  int requests_left      = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  reflectance_discharge_classifier_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .command_i    (command),
    .pins_i       (pins),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .light_mask_o (light_mask),
    .timed_out_o  (timed_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count a failure; print only the first ten in detail.
  function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= 10) begin
      $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    end
  endfunction

  // Advance the discharge state by one accepted request and queue the reading it finishes.
  function automatic void predict_discharge(logic cmd, logic [NCH-1:0] level);
    logic [NCH-1:0] flipped;
    logic [NCH-1:0] below;
    logic [COUNT_W:0] outer_limit;
    logic all_done;
    logic expired;
    if (cmd == CMD_START) begin
      // Open a fresh measurement, dropping any running one silently.
      light_seen    = '0;
      done_seen     = '0;
      elapsed_count = '0;
      last_pins     = '1;
      measuring     = 1'b1;
      return;
    end
    if (!measuring) return;
    flipped = level ^ last_pins;
    // Outer lanes allow threshold plus margin, summed one bit wider so it never wraps.
    outer_limit = cfg_threshold + cfg_margin;
    below = '0;
    if (elapsed_count < cfg_threshold) below = ~OUTER_LANES;
    if ({1'b0, elapsed_count} < outer_limit) below = below | OUTER_LANES;
    light_seen = light_seen | (flipped & below);
    done_seen  = done_seen | flipped;
    last_pins  = level;
    if (elapsed_count != COUNT_MAX) elapsed_count = elapsed_count + 1'b1;
    all_done = &done_seen;
    expired  = elapsed_count >= cfg_timeout;
    if (all_done || expired) begin
      // Finishing on the same tick as the timeout still counts as finished.
      expected_readings.push_back('{light_mask: light_seen, timed_out: !all_done});
      measuring = 1'b0;
    end
  endfunction

  // Predict on accepted requests, then check accepted results against the oldest reading.
  always @(posedge clk) begin : monitor
    reading_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_discharge(command, pins);
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result {timed_out,light_mask}", '0,
                          32'({timed_out, light_mask}));
        end else begin
          want = expected_readings.pop_front();
          if (light_mask !== want.light_mask) begin
            report_mismatch("light_mask", 32'(want.light_mask), 32'(light_mask));
          end
          if (timed_out !== want.timed_out) begin
            report_mismatch("timed_out", 32'(want.timed_out), 32'(timed_out));
          end
        end
      end
    end
  end

  // Abort when neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stall the result channel at the rate of the current phase.
  always @(negedge clk) begin
    out_ready = (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
  end

  // Send one request. Enter and leave at a falling edge, so the predictor has run on return.
  task automatic send_request(input logic cmd, input logic [NCH-1:0] level);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command  = cmd;
    pins     = level;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold requests back until every queued reading has arrived, then let the core settle.
  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Finish a running measurement by discharging every lane at once.
  task automatic close_measurement();
    if (measuring) send_request(CMD_TICK, ~last_pins);
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_LIGHT_THRESHOLD: cfg_threshold = data[COUNT_W-1:0];
      REG_EDGE_MARGIN:     cfg_margin    = data[MARGIN_W-1:0];
      REG_TIMEOUT_COUNT:   cfg_timeout   = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apb_read_check(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] want,
                                input string what);
    logic [APB_DW-1:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== want) report_mismatch(what, want, got);
  endtask

  // Write all three registers with junk above each field, then read them back.
  task automatic set_config(input logic [COUNT_W-1:0] threshold,
                            input logic [MARGIN_W-1:0] margin,
                            input logic [COUNT_W-1:0] timeout);
    apb_write(REG_LIGHT_THRESHOLD, ($urandom() & 32'hFFFF_0000) | 32'(threshold));
    apb_write(REG_EDGE_MARGIN,     ($urandom() & 32'hFFFF_F000) | 32'(margin));
    apb_write(REG_TIMEOUT_COUNT,   ($urandom() & 32'hFFFF_0000) | 32'(timeout));
    apb_read_check(REG_LIGHT_THRESHOLD, 32'(cfg_threshold), "light_threshold readback");
    apb_read_check(REG_EDGE_MARGIN,     32'(cfg_margin),    "edge_margin readback");
    apb_read_check(REG_TIMEOUT_COUNT,   32'(cfg_timeout),   "timeout_count readback");
  endtask

  task automatic test_reset_values();
    apb_read_check(REG_LIGHT_THRESHOLD, 32'(THRESHOLD_RESET), "light_threshold reset");
    apb_read_check(REG_EDGE_MARGIN,     32'(MARGIN_RESET),    "edge_margin reset");
    apb_read_check(REG_TIMEOUT_COUNT,   32'(TIMEOUT_RESET),   "timeout_count reset");
  endtask

  task automatic test_directed_cases();
    set_config(16'd3, 12'd2, 16'd10);
    // Tick with no measurement open: drop it.
    send_request(CMD_TICK, 5'b00000);
    // Every lane discharges on the first tick: all light.
    send_request(CMD_START, 5'b10101);
    send_request(CMD_TICK, 5'b00000);
    // Inner lanes early, outer lanes just past threshold plus margin: outer dark.
    send_request(CMD_START, 5'b00000);
    send_request(CMD_TICK, 5'b11111);
    repeat (4) send_request(CMD_TICK, 5'b10001);
    send_request(CMD_TICK, 5'b00001);
    send_request(CMD_TICK, 5'b00000);
    // Outer lanes on the last light count, inner lanes late: outer light only.
    send_request(CMD_START, 5'b11111);
    repeat (4) send_request(CMD_TICK, 5'b11111);
    send_request(CMD_TICK, 5'b01110);
    send_request(CMD_TICK, 5'b00000);
    // Restart mid-measurement, then toggle one lane twice and run into the timeout.
    send_request(CMD_START, 5'b00000);
    send_request(CMD_TICK, 5'b11110);
    send_request(CMD_START, 5'b00000);
    send_request(CMD_TICK, 5'b11111);
    send_request(CMD_TICK, 5'b11110);
    send_request(CMD_TICK, 5'b11111);
    repeat (8) send_request(CMD_TICK, 5'b11111);
    drain_results();

    // All lanes finish on the very tick the timeout is reached.
    set_config(16'd3, 12'd2, 16'd4);
    send_request(CMD_START, 5'b00000);
    repeat (3) send_request(CMD_TICK, 5'b11111);
    send_request(CMD_TICK, 5'b00000);
    drain_results();

    // Shortest timeout with zero threshold and margin: nothing reads light.
    set_config(16'd0, 12'd0, 16'd1);
    send_request(CMD_START, 5'b00000);
    send_request(CMD_TICK, 5'b11111);
    send_request(CMD_START, 5'b00000);
    send_request(CMD_TICK, 5'b01010);
    drain_results();

    // Widest threshold and margin.
    set_config(16'hFFFF, 12'hFFF, 16'd1);
    send_request(CMD_START, 5'b00000);
    send_request(CMD_TICK, 5'b00000);
    drain_results();
  endtask

  // Threshold plus margin lands just past 16 bits: a wrapped sum would be zero, yet the
  // outer lanes must still read light late into the measurement.
  task automatic test_long_discharge();
    set_config(16'hF100, 12'hF00, 16'd200);
    send_request(CMD_START, 5'b11111);
    for (int count = 0; count < 200; count++) begin
      send_request(CMD_TICK, (count < 100) ? 5'b11111 :
                             (count == 199) ? 5'b01100 : 5'b11100);
    end
    drain_results();
  endtask

  // One measurement with random discharge times per lane, stray toggles and restarts.
  task automatic run_random_measurement();
    int unsigned fall_at[NCH];
    int unsigned span;
    int unsigned tick_no;
    logic [NCH-1:0] level;
    span = ((cfg_timeout > 60) ? 60 : int'(cfg_timeout)) + 4;
    // Occasional stray tick; ignored whenever no measurement is open.
    if ($urandom_range(19) == 0) send_request(CMD_TICK, NCH'($urandom_range(31)));
    send_request(CMD_START, NCH'($urandom_range(31)));
    requests_left--;
    foreach (fall_at[c]) fall_at[c] = $urandom_range(span);
    tick_no = 0;
    while (measuring && requests_left > 0) begin
      if ($urandom_range(49) == 0) begin
        // Abandon the measurement and start over.
        send_request(CMD_START, NCH'($urandom_range(31)));
        foreach (fall_at[c]) fall_at[c] = $urandom_range(span);
        tick_no = 0;
      end else begin
        foreach (level[c]) level[c] = (tick_no < fall_at[c]);
        if ($urandom_range(11) == 0) level[$urandom_range(NCH - 1)] ^= 1'b1;
        send_request(CMD_TICK, level);
        tick_no++;
      end
      requests_left--;
    end
    // Now and then hold the sender until every reading is back.
    if (!measuring && $urandom_range(9) == 0) drain_results();
  endtask

  task automatic test_random_traffic();
    int send_pcts[4] = '{0, 45, 0, 29};
    int recv_pcts[4] = '{0, 0, 45, 29};
    logic [COUNT_W-1:0] threshold;
    logic [MARGIN_W-1:0] margin;
    logic [COUNT_W-1:0] timeout;
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = send_pcts[phase];
      receiver_stall_pct = recv_pcts[phase];
      for (int setting = 0; setting < 3; setting++) begin
        close_measurement();
        drain_results();
        // Mostly small values so light, dark and timeout all occur; extremes now and then.
        threshold = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'd0)
                                             : COUNT_W'($urandom_range(40));
        margin    = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 12'hFFF : 12'd0)
                                             : MARGIN_W'($urandom_range(20));
        timeout   = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'd1)
                                             : COUNT_W'($urandom_range(60, 1));
        set_config(threshold, margin, timeout);
        requests_left = 135;
        while (requests_left > 0) run_random_measurement();
      end
    end
    close_measurement();
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_values();
    test_directed_cases();
    test_long_discharge();
    test_random_traffic();

    drain_results();
    repeat (8) @(negedge clk);
    if (expected_readings.size() != 0) begin
      report_mismatch("readings left over", 32'd0, 32'(expected_readings.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
